[hw/rtl/code_region_crc_integrity_monitor_top_macros.svh]
// assertion macros shared by the rtl
`ifndef CODE_REGION_CRC_INTEGRITY_MONITOR_TOP_MACROS_SVH
`define CODE_REGION_CRC_INTEGRITY_MONITOR_TOP_MACROS_SVH

// checked only out of reset
`define CRCM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("crcm assertion failed");

// checked on every edge
`define CRCM_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("crcm assertion failed");

`endif

[hw/rtl/crcm_pkg.sv]
`timescale 1ns / 1ps
package crcm_pkg;

  localparam int MaxEntries = 8;
  localparam int IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int EcW = $clog2(MaxEntries + 1);
  localparam int QDepth = 4;

  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [6:0] RegionLenReset = 7'd32;
  localparam logic [6:0] RegionLenMax = 7'd64;
  localparam logic [7:0] ViolMax = 8'd255;

  typedef enum logic [1:0] {
    CMD_CAPTURE = 2'd0,
    CMD_VERIFY  = 2'd1,
    CMD_FINISH  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_OK       = 3'd2,
    ST_MODIFIED = 3'd3,
    ST_UNUSED   = 3'd4,
    ST_PASS     = 3'd5,
    ST_FAIL     = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    OP_CAPTURE = 2'd0,
    OP_VERIFY  = 2'd1,
    OP_FINISH  = 2'd2
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [2:0]  slot;
    logic [31:0] crc;
  } op_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  entry_slot;
    logic [31:0] current_crc;
    logic [31:0] baseline_crc;
    logic [7:0]  violation_total;
  } res_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hw/rtl/code_region_crc_integrity_monitor_top.sv]
`timescale 1ns / 1ps
// a result passes through the op queue write and then the result register after the item
// that closes its region or the finish item is accepted
// throughput: one item per cycle while the op queue is not full; the four-entry op queue absorbs result stalls
// reset: region length 32, crc all ones, byte, entry and violation counts zero
// baseline table contents are undefined until a capture region writes them
module code_region_crc_integrity_monitor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic [2:0]  slot_i,
  input  logic [7:0]  data_byte_i,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [2:0]  entry_slot_o,
  output logic [31:0] current_crc_o,
  output logic [31:0] baseline_crc_o,
  output logic [7:0]  violation_total_o
);
  import crcm_pkg::*;

  logic fe_valid, q_valid, q_ready, res_valid;
  op_t  fe_op, q_op;
  res_t res;

  crcm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_i      (full),
    .command_i   (command_i),
    .slot_i      (slot_i),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_valid_o  (fe_valid),
    .op_o        (fe_op)
  );

  crcm_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_op_i    (fe_op),
    .full_o     (full),
    .rd_ready_i (q_ready),
    .rd_valid_o (q_valid),
    .rd_op_o    (q_op)
  );

  crcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_op),
    .op_ready_o  (q_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign empty = !res_valid;
  assign status_o = res.status;
  assign entry_slot_o = res.entry_slot;
  assign current_crc_o = res.current_crc;
  assign baseline_crc_o = res.baseline_crc;
  assign violation_total_o = res.violation_total;

endmodule

[hw/rtl/crcm_front.sv]
`timescale 1ns / 1ps
module crcm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  logic [1:0]        command_i,
  input  logic [2:0]        slot_i,
  input  logic [7:0]        data_byte_i,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  output logic              op_valid_o,
  output crcm_pkg::op_t     op_o
);
  import crcm_pkg::*;

  logic [6:0]  region_len_q;
  logic [31:0] crc_q, crc_d;
  logic [6:0]  seen_q, seen_d;
  logic [6:0]  len_eff;
  logic [6:0]  seen_inc;
  logic [31:0] crc_next;
  logic        accept;

  assign accept = push_i && !full_i;
  assign len_eff = (region_len_q == 7'd0) ? 7'd1 :
                   (region_len_q > RegionLenMax) ? RegionLenMax : region_len_q;
  assign crc_next = crc_byte(crc_q, data_byte_i);
  assign seen_inc = seen_q + 7'd1;

  always_comb begin
    crc_d = crc_q;
    seen_d = seen_q;
    op_valid_o = 1'b0;
    op_o.kind = OP_FINISH;
    op_o.slot = slot_i;
    op_o.crc = ~crc_next;
    if (accept) begin
      case (command_i)
        CMD_FINISH: begin
          crc_d = CrcInit;
          seen_d = 7'd0;
          op_valid_o = 1'b1;
          op_o.kind = OP_FINISH;
        end
        CMD_CAPTURE, CMD_VERIFY: begin
          op_o.kind = (command_i == CMD_CAPTURE) ? OP_CAPTURE : OP_VERIFY;
          if (seen_inc >= len_eff) begin
            crc_d = CrcInit;
            seen_d = 7'd0;
            op_valid_o = 1'b1;
          end else begin
            crc_d = crc_next;
            seen_d = seen_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_len_q <= RegionLenReset;
      crc_q <= CrcInit;
      seen_q <= 7'd0;
    end else begin
      if (cfg_we_i) begin
        region_len_q <= cfg_wdata_i;
      end
      crc_q <= crc_d;
      seen_q <= seen_d;
    end
  end

endmodule

[hw/rtl/crcm_fifo.sv]
`timescale 1ns / 1ps
`include "code_region_crc_integrity_monitor_top_macros.svh"
module crcm_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  input  crcm_pkg::op_t wr_op_i,
  output logic          full_o,
  input  logic          rd_ready_i,
  output logic          rd_valid_o,
  output crcm_pkg::op_t rd_op_o
);
  import crcm_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  op_t             mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o = (cnt_q == CntW'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_op_o = mem_q[rd_ptr_q];
  assign do_wr = wr_valid_i && !full_o;
  assign do_rd = rd_ready_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `CRCM_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntW'(QDepth))
  `CRCM_ASSERT(a_cnt_step, (do_wr && !do_rd) |=> cnt_q == $past(cnt_q) + 1'b1)
  `CRCM_ASSERT(a_empty_ptrs, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))

endmodule

[hw/rtl/crcm_back.sv]
`timescale 1ns / 1ps
`include "code_region_crc_integrity_monitor_top_macros.svh"
module crcm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           op_valid_i,
  input  crcm_pkg::op_t  op_i,
  output logic           op_ready_o,
  output logic           res_valid_o,
  output crcm_pkg::res_t res_o,
  input  logic           res_pop_i
);
  import crcm_pkg::*;

  logic [31:0]    table_q [MaxEntries];
  logic [EcW-1:0] ec_q, ec_d;
  logic [7:0]     viol_q, viol_d;
  logic           out_valid_q, out_valid_d;
  res_t           out_q, out_d;
  logic           take;
  logic           tbl_we;
  logic [EcW+2:0] slot_wide, ec_wide;
  logic [31:0]    base_rd;
  logic [7:0]     viol_inc;

  assign take = op_valid_i && (!out_valid_q || res_pop_i);
  assign op_ready_o = take;
  assign slot_wide = {{EcW{1'b0}}, op_i.slot};
  assign ec_wide = {3'd0, ec_q};
  assign base_rd = table_q[slot_wide[IdxW-1:0]];
  assign viol_inc = (viol_q == ViolMax) ? viol_q : viol_q + 8'd1;

  always_comb begin
    ec_d = ec_q;
    viol_d = viol_q;
    tbl_we = 1'b0;
    out_valid_d = out_valid_q && !res_pop_i;
    out_d = out_q;
    if (take) begin
      out_d.entry_slot = op_i.slot;
      out_d.current_crc = op_i.crc;
      out_d.baseline_crc = 32'd0;
      out_d.violation_total = viol_q;
      case (op_i.kind)
        OP_FINISH: begin
          out_valid_d = 1'b1;
          out_d.status = ((ec_q == '0) || (viol_q != 8'd0)) ? ST_FAIL : ST_PASS;
          out_d.entry_slot = 3'd0;
          out_d.current_crc = 32'd0;
          viol_d = 8'd0;
        end
        OP_CAPTURE: begin
          out_valid_d = 1'b1;
          if (ec_wide >= (EcW + 3)'(MaxEntries)) begin
            out_d.status = ST_FULL;
            out_d.entry_slot = 3'd0;
          end else begin
            out_d.status = ST_STORED;
            out_d.entry_slot = ec_wide[2:0];
            out_d.baseline_crc = op_i.crc;
            tbl_we = 1'b1;
            ec_d = ec_q + 1'b1;
          end
        end
        OP_VERIFY: begin
          out_valid_d = 1'b1;
          if ((slot_wide >= ec_wide) || (slot_wide >= (EcW + 3)'(MaxEntries))) begin
            out_d.status = ST_UNUSED;
          end else if (op_i.crc != base_rd) begin
            out_d.status = ST_MODIFIED;
            out_d.baseline_crc = base_rd;
            out_d.violation_total = viol_inc;
            viol_d = viol_inc;
          end else begin
            out_d.status = ST_OK;
            out_d.baseline_crc = base_rd;
          end
        end
        default: begin
          out_valid_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      table_q[ec_wide[IdxW-1:0]] <= op_i.crc;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_q <= '0;
      viol_q <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      ec_q <= ec_d;
      viol_q <= viol_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o = out_q;

  `CRCM_ASSERT_ALWAYS(a_ec_bound, ec_wide <= (EcW + 3)'(MaxEntries))
  `CRCM_ASSERT(a_ec_grows, (ec_q != $past(ec_q)) |-> (ec_q == $past(ec_q) + 1'b1))
  `CRCM_ASSERT(a_viol_sat, (viol_q == ViolMax && !take) |=> viol_q == ViolMax)

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import crcm_pkg::*;

  localparam logic [1:0]  CmdIgnored  = 2'd3;
  localparam logic [31:0] CrcOfFF     = 32'hFF00_0000;  // crc-32 of the single byte ff
  localparam int          NumPlan     = 26;
  localparam int          NumPhases   = 6;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned StallLimit  = 4000;

  typedef struct packed {
    bit          is_cfg;
    logic [6:0]  len;
    logic [1:0]  cmd;
    logic [2:0]  slot;
    logic [7:0]  data;
    bit          typed;
    res_t        want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [1:0]  command;
  logic [2:0]  slot_sel;
  logic [7:0]  code_byte;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        empty;
  logic        pop;
  logic [2:0]  status;
  logic [2:0]  entry_slot;
  logic [31:0] current_crc;
  logic [31:0] baseline_crc;
  logic [7:0]  violation_total;

  bit          exp_typed;
  res_t        exp_fixed;
  bit          send_calm;

  // predictor state
  logic [6:0]  region_len = RegionLenReset;
  logic [31:0] crc_acc = CrcInit;
  logic [6:0]  byte_cnt = 7'd0;
  logic [3:0]  entries = 4'd0;
  logic [7:0]  violations = 8'd0;
  logic [31:0] baselines [MaxEntries];
  logic [7:0]  region_buf [64];
  logic [7:0]  img_data [MaxEntries][64];
  int unsigned img_len [MaxEntries] = '{default: 0};

  res_t        pending_outcomes [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;

  plan_row_t   plan [NumPlan];
  logic [6:0]  phase_len [NumPhases];
  int unsigned phase_items [NumPhases];

  code_region_crc_integrity_monitor_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push             (push),
    .full             (full),
    .command_i        (command),
    .slot_i           (slot_sel),
    .data_byte_i      (code_byte),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .empty            (empty),
    .pop              (pop),
    .status_o         (status),
    .entry_slot_o     (entry_slot),
    .current_crc_o    (current_crc),
    .baseline_crc_o   (baseline_crc),
    .violation_total_o(violation_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] crc32_shift_byte(logic [31:0] c, logic [7:0] b);
    logic fb;
    int   k;
    for (k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c = c >> 1;
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  function automatic int unsigned span_of(logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > RegionLenMax) return RegionLenMax;
    return v;
  endfunction

  function automatic int unsigned idle_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit region_outcome(input logic [1:0] op, input logic [2:0] sl,
                                        input logic [7:0] b, output res_t r);
    logic [31:0] crc;
    int unsigned done_len;
    int unsigned i;
    r = '0;
    if (op == CMD_FINISH) begin
      r.status = (entries == 4'd0 || violations != 8'd0) ? ST_FAIL : ST_PASS;
      r.violation_total = violations;
      violations = 8'd0;
      crc_acc = CrcInit;
      byte_cnt = 7'd0;
      return 1'b1;
    end
    if (op == CmdIgnored) return 1'b0;
    region_buf[byte_cnt[5:0]] = b;
    crc_acc = crc32_shift_byte(crc_acc, b);
    byte_cnt = byte_cnt + 7'd1;
    if (byte_cnt < span_of(region_len)) return 1'b0;
    crc = ~crc_acc;
    done_len = byte_cnt;
    crc_acc = CrcInit;
    byte_cnt = 7'd0;
    r.current_crc = crc;
    if (op == CMD_CAPTURE) begin
      if (entries >= MaxEntries) begin
        r.status = ST_FULL;
      end else begin
        r.status = ST_STORED;
        r.entry_slot = entries[2:0];
        r.baseline_crc = crc;
        baselines[entries[2:0]] = crc;
        img_len[entries[2:0]] = done_len;
        for (i = 0; i < done_len; i++) img_data[entries[2:0]][i] = region_buf[i];
        entries = entries + 4'd1;
      end
    end else begin
      r.entry_slot = sl;
      if (sl >= entries) begin
        r.status = ST_UNUSED;
      end else if (crc != baselines[sl]) begin
        r.status = ST_MODIFIED;
        r.baseline_crc = baselines[sl];
        if (violations != ViolMax) violations = violations + 8'd1;
      end else begin
        r.status = ST_OK;
        r.baseline_crc = baselines[sl];
      end
    end
    r.violation_total = violations;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
  endtask

  always @(posedge clk) begin : observe
    res_t want;
    res_t outcome;
    bit   has_outcome;
    if (rst_n) begin
      if (pop && !empty) begin
        if (pending_outcomes.size() == 0) begin
          flag_mismatch("result with none expected", {29'd0, status}, 32'd0);
        end else begin
          want = pending_outcomes.pop_front();
          if (status !== want.status)
            flag_mismatch("status", {29'd0, status}, {29'd0, want.status});
          if (entry_slot !== want.entry_slot)
            flag_mismatch("entry_slot", {29'd0, entry_slot}, {29'd0, want.entry_slot});
          if (current_crc !== want.current_crc)
            flag_mismatch("current_crc", current_crc, want.current_crc);
          if (baseline_crc !== want.baseline_crc)
            flag_mismatch("baseline_crc", baseline_crc, want.baseline_crc);
          if (violation_total !== want.violation_total)
            flag_mismatch("violation_total", {24'd0, violation_total},
                          {24'd0, want.violation_total});
        end
      end
      if (push && !full) begin
        has_outcome = region_outcome(command, slot_sel, code_byte, outcome);
        if (exp_typed) pending_outcomes.push_back(exp_fixed);
        else if (has_outcome) pending_outcomes.push_back(outcome);
      end
      if (cfg_we) region_len = cfg_wdata;
      if ((push && !full) || (pop && !empty) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  task automatic send_item(logic [1:0] op, logic [2:0] sl, logic [7:0] b,
                           bit typed, res_t fixed);
    int unsigned gap;
    gap = idle_gap(send_calm);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    command   <= op;
    slot_sel  <= sl;
    code_byte <= b;
    exp_typed <= typed;
    exp_fixed <= fixed;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain_outcomes();
    push <= 1'b0;
    exp_typed <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_len(logic [6:0] v);
    drain_outcomes();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned p, i, sent, span, flip_at, r;
    bit          capture_run, replay;
    logic [1:0]  op;
    logic [2:0]  sl;
    logic [7:0]  b;
    rst_n     <= 1'b0;
    push      <= 1'b0;
    command   <= CMD_CAPTURE;
    slot_sel  <= 3'd0;
    code_byte <= 8'd0;
    cfg_we    <= 1'b0;
    cfg_wdata <= 7'd0;
    exp_typed <= 1'b0;
    exp_fixed <= '0;
    send_calm = 1'b0;
    plan = '{
      '{1'b0, 7'd0, CMD_FINISH,  3'd0, 8'h00, 1'b1, res_t'{ST_FAIL, 3'd0, 32'd0, 32'd0, 8'd0}},
      '{1'b0, 7'd0, CmdIgnored,  3'd7, 8'hFF, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_CAPTURE, 3'd0, 8'h3C, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_FINISH,  3'd0, 8'h00, 1'b1, res_t'{ST_FAIL, 3'd0, 32'd0, 32'd0, 8'd0}},
      '{1'b1, 7'd1, CMD_CAPTURE, 3'd0, 8'h00, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_VERIFY,  3'd7, 8'hFF, 1'b1,
        res_t'{ST_UNUSED, 3'd7, CrcOfFF, 32'd0, 8'd0}},
      '{1'b0, 7'd0, CMD_CAPTURE, 3'd0, 8'hFF, 1'b1,
        res_t'{ST_STORED, 3'd0, CrcOfFF, CrcOfFF, 8'd0}},
      '{1'b0, 7'd0, CMD_VERIFY,  3'd0, 8'hFF, 1'b1,
        res_t'{ST_OK, 3'd0, CrcOfFF, CrcOfFF, 8'd0}},
      '{1'b0, 7'd0, CMD_VERIFY,  3'd0, 8'h00, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_FINISH,  3'd0, 8'h00, 1'b1, res_t'{ST_FAIL, 3'd0, 32'd0, 32'd0, 8'd1}},
      '{1'b0, 7'd0, CMD_FINISH,  3'd0, 8'h00, 1'b1, res_t'{ST_PASS, 3'd0, 32'd0, 32'd0, 8'd0}},
      '{1'b1, 7'd2, CMD_CAPTURE, 3'd0, 8'h00, 1'b0, res_t'('0)},
      // the byte that closes a region decides capture or verify
      '{1'b0, 7'd0, CMD_CAPTURE, 3'd0, 8'hA5, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_VERIFY,  3'd0, 8'h5A, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_VERIFY,  3'd5, 8'h00, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_CAPTURE, 3'd2, 8'hFF, 1'b0, res_t'('0)},
      '{1'b1, 7'd0, CMD_CAPTURE, 3'd0, 8'h00, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_CAPTURE, 3'd1, 8'h00, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_CAPTURE, 3'd2, 8'h80, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_CAPTURE, 3'd3, 8'h01, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_CAPTURE, 3'd4, 8'h7F, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_CAPTURE, 3'd5, 8'hFE, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_CAPTURE, 3'd6, 8'h10, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_CAPTURE, 3'd7, 8'hFF, 1'b1,
        res_t'{ST_FULL, 3'd0, CrcOfFF, 32'd0, 8'd1}},
      '{1'b0, 7'd0, CMD_VERIFY,  3'd2, 8'h00, 1'b0, res_t'('0)},
      '{1'b0, 7'd0, CMD_FINISH,  3'd3, 8'hFF, 1'b1, res_t'{ST_FAIL, 3'd0, 32'd0, 32'd0, 8'd1}}
    };
    phase_len   = '{7'd1, 7'd3, 7'd127, 7'd2, 7'd0, 7'd64};
    phase_len[4] = 7'($urandom_range(4, 12));
    phase_items = '{80, 35, 50, 30, 30, 50};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NumPlan; i++) begin
      if (plan[i].is_cfg) write_len(plan[i].len);
      else send_item(plan[i].cmd, plan[i].slot, plan[i].data, plan[i].typed, plan[i].want);
    end

    for (p = 0; p < NumPhases; p++) begin
      write_len(phase_len[p]);
      span = span_of(phase_len[p]);
      send_calm = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < phase_items[p]) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_item(CMD_FINISH, 3'($urandom), 8'($urandom), 1'b0, '0);
          sent++;
        end else if (r < 13) begin
          send_item(2'($urandom_range(0, 3)), 3'($urandom), 8'($urandom), 1'b0, '0);
          sent++;
        end else begin
          capture_run = ($urandom_range(0, 9) == 0);
          sl = 3'($urandom);
          replay = !capture_run && img_len[sl] == span && $urandom_range(0, 2) != 0;
          flip_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, span - 1) : span;
          for (i = 0; i < span; i++) begin
            op = capture_run ? CMD_CAPTURE : CMD_VERIFY;
            if (i + 1 < span && $urandom_range(0, 19) == 0) op = 2'($urandom_range(0, 1));
            b = replay ? img_data[sl][i] : 8'($urandom);
            if (i == flip_at) b = b ^ (8'd1 << $urandom_range(0, 7));
            send_item(op, sl, b, 1'b0, '0);
          end
          sent += span;
        end
      end
    end

    // push the violation count into saturation
    write_len(7'd1);
    send_calm = 1'b0;
    for (i = 0; i < 260; i++)
      send_item(CMD_VERIFY, 3'd0, 8'($urandom_range(0, 254)), 1'b0, '0);
    send_item(CMD_FINISH, 3'd0, 8'd0, 1'b0, '0);

    drain_outcomes();
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : result_side
    int unsigned gap, taken;
    bit          calm;
    pop <= 1'b0;
    calm = 1'b0;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = idle_gap(calm);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      taken++;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= StallLimit);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
